@@ rtl/ffca_pkg.sv @@
// Package for the first-fit cell allocator: command, status and position codes,
// the cell descriptor layout, and the command/status bundles between controller
// and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ffca_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2,
    CMD_CHECK   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_ROOM   = 3'd1,
    ST_OUTSIDE   = 3'd2,
    ST_NULL      = 3'd3,
    ST_NOT_ALLOC = 3'd4,
    ST_NOT_START = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    POS_LONELY = 2'd0,
    POS_HEAD   = 2'd1,
    POS_MIDDLE = 2'd2,
    POS_TAIL   = 2'd3
  } pos_t;

  // Bit 0 is the allocated flag, bits 2:1 the position.
  typedef struct packed {
    pos_t pos;
    logic alloc;
  } desc_t;

  typedef enum logic [1:0] {
    RSEL_IDX  = 2'd0,
    RSEL_IDX1 = 2'd1,
    RSEL_PTR  = 2'd2
  } rsel_t;

  typedef enum logic [1:0] {
    WSEL_ZERO_IDX = 2'd0,
    WSEL_ZERO_EVL = 2'd1,
    WSEL_ZERO_PTR = 2'd2,
    WSEL_MARK     = 2'd3
  } wsel_t;

  typedef struct packed {
    logic    load_req;
    logic    rd_en;
    rsel_t   rd_sel;
    logic    wr_en;
    wsel_t   wr_sel;
    logic    ptr_adv;
    logic    ptr_load_idx2;
    logic    srch_init;
    logic    srch_eval;
    logic    mark_load;
    logic    res_load;
    status_t res_status;
    logic    res_use_start;
    logic    out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic bad_size;
    logic is_null;
    logic outside;
    logic idx_last;
    logic ptr_last;
    logic ptr_in_pool;
    logic rdv;
    pos_t rd_pos;
    logic rd_alloc;
    logic evl_last;
    logic srch_hit;
    logic mark_last;
    logic out_busy;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ rtl/ffca_if.sv @@
// Valid/ready channel interfaces for the allocator's request and result sides.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

interface ffca_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [7:0] size_cells;
  logic [7:0] cell_index;
  logic       pointer_is_null;

  modport source (output valid, output command, output size_cells, output cell_index,
                  output pointer_is_null, input ready);
  modport sink (input valid, input command, input size_cells, input cell_index,
                input pointer_is_null, output ready);
endinterface

interface ffca_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [5:0] block_start;

  modport source (output valid, output status, output block_start, input ready);
  modport sink (input valid, input status, input block_start, output ready);
endinterface

`default_nettype wire

@@ rtl/ffca_ctrl.sv @@
// Allocator controller: one-hot sequencer for clear, decode, check, free walk,
// first-fit search and mark. Drives the datapath via ffca_pkg::dp_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module ffca_ctrl (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire ffca_pkg::dp_sts_t sts,
  output ffca_pkg::dp_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_CLEAR     = 9'b000000001,
    S_IDLE      = 9'b000000010,
    S_DECODE    = 9'b000000100,
    S_CHECK     = 9'b000001000,
    S_FREE_HD   = 9'b000010000,
    S_FREE_WALK = 9'b000100000,
    S_SEARCH    = 9'b001000000,
    S_MARK      = 9'b010000000,
    S_DONE      = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   free_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    free_done = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ffca_pkg::WSEL_ZERO_PTR;
        cmd.ptr_adv = 1'b1;
        if (sts.ptr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.cmd == ffca_pkg::CMD_ALLOC) begin
          if (sts.bad_size) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffca_pkg::ST_NO_ROOM;
            state_nxt      = S_DONE;
          end else begin
            cmd.srch_init = 1'b1;
            state_nxt     = S_SEARCH;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = ffca_pkg::RSEL_IDX;
          if (sts.is_null) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffca_pkg::ST_NULL;
            state_nxt      = S_DONE;
          end else if (sts.outside) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffca_pkg::ST_OUTSIDE;
            state_nxt      = S_DONE;
          end else if (sts.cmd == ffca_pkg::CMD_CHECK) begin
            state_nxt = S_CHECK;
          end else begin
            state_nxt = S_FREE_HD;
          end
        end
      end
      S_CHECK: begin
        cmd.res_load = 1'b1;
        if (!sts.rd_alloc) begin
          cmd.res_status = ffca_pkg::ST_NOT_ALLOC;
        end else if (sts.rd_pos == ffca_pkg::POS_MIDDLE ||
                     sts.rd_pos == ffca_pkg::POS_TAIL) begin
          cmd.res_status = ffca_pkg::ST_NOT_START;
        end else begin
          cmd.res_status = ffca_pkg::ST_OK;
        end
        state_nxt = S_DONE;
      end
      S_FREE_HD: begin
        if (sts.rd_pos == ffca_pkg::POS_MIDDLE || sts.rd_pos == ffca_pkg::POS_TAIL) begin
          free_done = 1'b1;
        end else begin
          cmd.wr_en  = 1'b1;
          cmd.wr_sel = ffca_pkg::WSEL_ZERO_IDX;
          if (sts.rd_pos == ffca_pkg::POS_HEAD && !sts.idx_last) begin
            // prefetch the next cell of the run
            cmd.rd_en         = 1'b1;
            cmd.rd_sel        = ffca_pkg::RSEL_IDX1;
            cmd.ptr_load_idx2 = 1'b1;
            state_nxt         = S_FREE_WALK;
          end else begin
            free_done = 1'b1;
          end
        end
      end
      S_FREE_WALK: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = ffca_pkg::WSEL_ZERO_EVL;
        if (sts.rd_pos == ffca_pkg::POS_TAIL || sts.evl_last) begin
          free_done = 1'b1;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_sel  = ffca_pkg::RSEL_PTR;
          cmd.ptr_adv = 1'b1;
        end
      end
      S_SEARCH: begin
        cmd.rd_en     = sts.ptr_in_pool;
        cmd.rd_sel    = ffca_pkg::RSEL_PTR;
        cmd.ptr_adv   = sts.ptr_in_pool;
        cmd.srch_eval = 1'b1;
        if (sts.srch_hit) begin
          cmd.mark_load = 1'b1;
          state_nxt     = S_MARK;
        end else if (sts.rdv && sts.evl_last) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffca_pkg::ST_NO_ROOM;
          state_nxt      = S_DONE;
        end
      end
      S_MARK: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = ffca_pkg::WSEL_MARK;
        cmd.ptr_adv = 1'b1;
        if (sts.mark_last) begin
          cmd.res_load      = 1'b1;
          cmd.res_status    = ffca_pkg::ST_OK;
          cmd.res_use_start = 1'b1;
          state_nxt         = S_DONE;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    if (free_done) begin
      if (sts.cmd == ffca_pkg::CMD_REALLOC) begin
        if (sts.bad_size) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffca_pkg::ST_NO_ROOM;
          state_nxt      = S_DONE;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_SEARCH;
        end
      end else begin
        cmd.res_load   = 1'b1;
        cmd.res_status = ffca_pkg::ST_OK;
        state_nxt      = S_DONE;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/ffca_dpath.sv @@
// Allocator datapath: descriptor memory with registered read, request registers,
// scan pointer and run counter, result and output registers. Uses ffca_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ffca_dpath #(
  parameter int POOL_CELLS = 64
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire ffca_pkg::dp_cmd_t cmd,
  output ffca_pkg::dp_sts_t      sts,
  input  wire [1:0]              req_command,
  input  wire [7:0]              req_size_cells,
  input  wire [7:0]              req_cell_index,
  input  wire                    req_pointer_is_null,
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [2:0]             out_status,
  output logic [5:0]             out_block_start
);

  localparam int IDX_W = $clog2(POOL_CELLS);
  localparam int PTR_W = $clog2(POOL_CELLS + 1);
  localparam int SZ_W  = (PTR_W > 8) ? PTR_W : 8;

  ffca_pkg::desc_t   mem [POOL_CELLS];

  logic [1:0]        cmd_r;
  logic [7:0]        size_r;
  logic [7:0]        idx_r;
  logic              null_r;
  logic [PTR_W-1:0]  ptr_r, ptr_nxt;
  logic [PTR_W-1:0]  run_r;
  logic [PTR_W-1:0]  start_r;
  logic [PTR_W-1:0]  last_r;
  logic [IDX_W-1:0]  raddr_r;
  logic              rdv_r;
  ffca_pkg::desc_t   rdata_r;
  ffca_pkg::status_t res_status_r;
  logic [5:0]        res_start_r;
  logic              out_valid_r;
  logic [2:0]        out_status_r;
  logic [5:0]        out_start_r;

  logic [SZ_W-1:0]   size_ext, idx_ext, idx1, idx2, found_start, start_ext;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  ffca_pkg::desc_t   wr_data;
  ffca_pkg::pos_t    mark_pos;
  logic              srch_hit;

  assign size_ext    = SZ_W'(size_r);
  assign idx_ext     = SZ_W'(idx_r);
  assign idx1        = idx_ext + SZ_W'(1);
  assign idx2        = idx_ext + SZ_W'(2);
  assign found_start = SZ_W'(raddr_r) + SZ_W'(1) - size_ext;
  assign start_ext   = SZ_W'(start_r);
  assign srch_hit    = rdv_r && !rdata_r.alloc &&
                       (SZ_W'(run_r) + SZ_W'(1) == size_ext);

  always_comb begin
    case (cmd.rd_sel)
      ffca_pkg::RSEL_IDX:  rd_addr = idx_ext[IDX_W-1:0];
      ffca_pkg::RSEL_IDX1: rd_addr = idx1[IDX_W-1:0];
      ffca_pkg::RSEL_PTR:  rd_addr = ptr_r[IDX_W-1:0];
      default:             rd_addr = ptr_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    if (size_r == 8'd1) begin
      mark_pos = ffca_pkg::POS_LONELY;
    end else if (ptr_r == start_r) begin
      mark_pos = ffca_pkg::POS_HEAD;
    end else if (ptr_r == last_r) begin
      mark_pos = ffca_pkg::POS_TAIL;
    end else begin
      mark_pos = ffca_pkg::POS_MIDDLE;
    end
  end

  always_comb begin
    wr_data.alloc = 1'b0;
    wr_data.pos   = ffca_pkg::POS_LONELY;
    case (cmd.wr_sel)
      ffca_pkg::WSEL_ZERO_IDX: wr_addr = idx_ext[IDX_W-1:0];
      ffca_pkg::WSEL_ZERO_EVL: wr_addr = raddr_r;
      ffca_pkg::WSEL_ZERO_PTR: wr_addr = ptr_r[IDX_W-1:0];
      ffca_pkg::WSEL_MARK: begin
        wr_addr       = ptr_r[IDX_W-1:0];
        wr_data.alloc = 1'b1;
        wr_data.pos   = mark_pos;
      end
      default: wr_addr = ptr_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    if (cmd.srch_init) begin
      ptr_nxt = '0;
    end else if (cmd.mark_load) begin
      ptr_nxt = found_start[PTR_W-1:0];
    end else if (cmd.ptr_load_idx2) begin
      ptr_nxt = idx2[PTR_W-1:0];
    end else if (cmd.ptr_adv) begin
      ptr_nxt = ptr_r + PTR_W'(1);
    end else begin
      ptr_nxt = ptr_r;
    end
  end

  // descriptor store
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[rd_addr];
      raddr_r <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r       <= '0;
      rdv_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      ptr_r <= ptr_nxt;
      rdv_r <= cmd.rd_en;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      cmd_r  <= req_command;
      size_r <= req_size_cells;
      idx_r  <= req_cell_index;
      null_r <= req_pointer_is_null;
    end
    if (cmd.srch_init) begin
      run_r <= '0;
    end else if (cmd.srch_eval && rdv_r) begin
      run_r <= rdata_r.alloc ? '0 : run_r + PTR_W'(1);
    end
    if (cmd.mark_load) begin
      start_r <= found_start[PTR_W-1:0];
      last_r  <= PTR_W'(raddr_r);
    end
    if (cmd.res_load) begin
      res_status_r <= cmd.res_status;
      res_start_r  <= cmd.res_use_start ? start_ext[5:0] : 6'd0;
    end
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_start_r  <= res_start_r;
    end
  end

  always_comb begin
    sts.cmd         = ffca_pkg::cmd_t'(cmd_r);
    sts.bad_size    = (size_r == 8'd0) || (size_ext > SZ_W'(POOL_CELLS));
    sts.is_null     = null_r;
    sts.outside     = idx_ext >= SZ_W'(POOL_CELLS);
    sts.idx_last    = idx_ext == SZ_W'(POOL_CELLS - 1);
    sts.ptr_last    = ptr_r == PTR_W'(POOL_CELLS - 1);
    sts.ptr_in_pool = ptr_r < PTR_W'(POOL_CELLS);
    sts.rdv         = rdv_r;
    sts.rd_pos      = rdata_r.pos;
    sts.rd_alloc    = rdata_r.alloc;
    sts.evl_last    = raddr_r == IDX_W'(POOL_CELLS - 1);
    sts.srch_hit    = srch_hit;
    sts.mark_last   = ptr_r == last_r;
    sts.out_busy    = out_valid_r && !out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_block_start = out_start_r;

endmodule

`default_nettype wire

@@ rtl/first_fit_cell_allocator.sv @@
// First-fit cell allocator top: ffca_ctrl sequencer plus ffca_dpath, with the
// request and result channels from ffca_if.sv. Requests are handled one at a time;
// a stalled result holds the next request's result until the output register is free.
// Allocate decodes, runs the first-fit scan and then marks the run; free walks the
// cells from head to tail, one cell per cycle.
// The descriptor memory port takes one read and one write per cycle.
// After reset a clearing pass over all POOL_CELLS cells runs before the first request.
`timescale 1ns / 1ps
`default_nettype none

module first_fit_cell_allocator #(
  parameter int POOL_CELLS = 64
) (
  input wire         clk,
  input wire         rst_n,
  ffca_req_if.sink   in_chan,
  ffca_rsp_if.source out_chan
);

  ffca_pkg::dp_cmd_t dp_cmd;
  ffca_pkg::dp_sts_t dp_sts;
  logic              ready;

  ffca_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (ready),
    .sts      (dp_sts),
    .cmd      (dp_cmd)
  );

  ffca_dpath #(
    .POOL_CELLS (POOL_CELLS)
  ) u_dpath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (dp_cmd),
    .sts                 (dp_sts),
    .req_command         (in_chan.command),
    .req_size_cells      (in_chan.size_cells),
    .req_cell_index      (in_chan.cell_index),
    .req_pointer_is_null (in_chan.pointer_is_null),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_status          (out_chan.status),
    .out_block_start     (out_chan.block_start)
  );

  assign in_chan.ready = ready;

endmodule

`default_nettype wire

@@ bench/tb_first_fit_cell_allocator.sv @@
`timescale 1ns / 1ps
// Self-checking bench for first_fit_cell_allocator: a directed request table, then a
// random request mix under changing idle and stall patterns.
// Depends on ffca_pkg, the ffca_req_if/ffca_rsp_if channels and the allocator RTL.

module tb_first_fit_cell_allocator;
  import ffca_pkg::*;

  localparam int POOL_CELLS = 64;
  localparam int RANDOM_PER_PHASE = 225;
  localparam int NUM_PHASES = 5;
  localparam int PRESSURE_CYCLES = 400;
  localparam int DRAIN_CYCLES = 4 * POOL_CELLS;
  localparam longint CYCLE_LIMIT = 1_000_000;
  localparam int N_DIRECTED = 25;
  localparam desc_t FREE_CELL = '{pos: POS_LONELY, alloc: 1'b0};

  typedef struct packed {
    status_t    status;
    logic [5:0] start;
  } grant_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] size;
    logic [7:0] idx;
    logic       null_ptr;
    logic       typed;
    status_t    status;
    logic [5:0] start;
  } stim_row_t;

  // Rows with typed set carry their own expected grant; the rest go to the predictor.
  stim_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_CHECK,   8'd0,   8'd0,   1'b0, 1'b1, ST_NOT_ALLOC, 6'd0},
    '{CMD_ALLOC,   8'd0,   8'd0,   1'b0, 1'b1, ST_NO_ROOM,   6'd0},
    '{CMD_ALLOC,   8'd65,  8'd0,   1'b0, 1'b1, ST_NO_ROOM,   6'd0},
    '{CMD_ALLOC,   8'd255, 8'd0,   1'b0, 1'b1, ST_NO_ROOM,   6'd0},
    '{CMD_ALLOC,   8'd1,   8'd255, 1'b1, 1'b1, ST_OK,        6'd0},
    '{CMD_ALLOC,   8'd3,   8'd0,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_CHECK,   8'd0,   8'd1,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_CHECK,   8'd0,   8'd2,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_CHECK,   8'd0,   8'd3,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_FREE,    8'd0,   8'd2,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_FREE,    8'd0,   8'd3,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_CHECK,   8'd0,   8'd1,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_FREE,    8'd0,   8'd255, 1'b1, 1'b1, ST_NULL,      6'd0},
    '{CMD_REALLOC, 8'd4,   8'd0,   1'b1, 1'b1, ST_NULL,      6'd0},
    '{CMD_CHECK,   8'd0,   8'd0,   1'b1, 1'b1, ST_NULL,      6'd0},
    '{CMD_FREE,    8'd0,   8'd64,  1'b0, 1'b1, ST_OUTSIDE,   6'd0},
    '{CMD_CHECK,   8'd0,   8'd255, 1'b0, 1'b1, ST_OUTSIDE,   6'd0},
    '{CMD_REALLOC, 8'd2,   8'd128, 1'b0, 1'b1, ST_OUTSIDE,   6'd0},
    '{CMD_FREE,    8'd0,   8'd1,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_FREE,    8'd0,   8'd10,  1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_ALLOC,   8'd64,  8'd0,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_REALLOC, 8'd64,  8'd0,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_CHECK,   8'd0,   8'd63,  1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_REALLOC, 8'd2,   8'd5,   1'b0, 1'b0, ST_OK,        6'd0},
    '{CMD_FREE,    8'd0,   8'd0,   1'b0, 1'b0, ST_OK,        6'd0}
  };

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffca_req_if req_if();
  ffca_rsp_if rsp_if();

  first_fit_cell_allocator #(.POOL_CELLS(POOL_CELLS)) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (rsp_if)
  );

  always #4 clk = ~clk;

  desc_t  pool_desc [POOL_CELLS];
  grant_t pending_grants [$];
  int     err_count = 0;
  longint cycle_count = 0;
  int     src_idle_pct = 0;
  int     sink_stall_pct = 0;
  logic   hold_grants = 1'b0;
  logic   pressure_go = 1'b0;
  logic   row_typed = 1'b0;
  grant_t row_grant = '0;

  // First fit: lowest run of free cells that is long enough.
  function automatic status_t carve_run(input int unsigned size, output logic [5:0] start);
    int unsigned run_len;
    int unsigned first;
    int unsigned i;
    bit          found;
    run_len = 0;
    first = 0;
    found = 1'b0;
    start = '0;
    if (size == 0 || size > POOL_CELLS) return ST_NO_ROOM;
    for (i = 0; i < POOL_CELLS && !found; i++) begin
      if (pool_desc[i].alloc) begin
        run_len = 0;
      end else begin
        run_len++;
        if (run_len == size) begin
          first = i + 1 - size;
          found = 1'b1;
        end
      end
    end
    if (!found) return ST_NO_ROOM;
    for (i = first; i < first + size; i++) begin
      pool_desc[i].alloc = 1'b1;
      if (size == 1) pool_desc[i].pos = POS_LONELY;
      else if (i == first) pool_desc[i].pos = POS_HEAD;
      else if (i == first + size - 1) pool_desc[i].pos = POS_TAIL;
      else pool_desc[i].pos = POS_MIDDLE;
    end
    start = first[5:0];
    return ST_OK;
  endfunction

  // Middle and tail cells are left alone; a head clears through its tail or the pool end.
  function automatic void release_run(input int unsigned idx);
    pos_t        first_pos;
    pos_t        p;
    int unsigned i;
    first_pos = pool_desc[idx].pos;
    if (first_pos == POS_MIDDLE || first_pos == POS_TAIL) return;
    pool_desc[idx] = FREE_CELL;
    if (first_pos != POS_HEAD) return;
    for (i = idx + 1; i < POOL_CELLS; i++) begin
      p = pool_desc[i].pos;
      pool_desc[i] = FREE_CELL;
      if (p == POS_TAIL) break;
    end
  endfunction

  function automatic grant_t predict_grant(input cmd_t cmd, input logic [7:0] size,
                                           input logic [7:0] idx, input logic null_ptr);
    grant_t     g;
    logic [5:0] s;
    g = '{status: ST_OK, start: 6'd0};
    s = '0;
    if (cmd == CMD_ALLOC) begin
      g.status = carve_run(size, s);
    end else if (null_ptr) begin
      g.status = ST_NULL;
    end else if (idx >= POOL_CELLS) begin
      g.status = ST_OUTSIDE;
    end else if (cmd == CMD_FREE) begin
      release_run(idx);
    end else if (cmd == CMD_REALLOC) begin
      release_run(idx);
      g.status = carve_run(size, s);
    end else if (!pool_desc[idx].alloc) begin
      g.status = ST_NOT_ALLOC;
    end else if (pool_desc[idx].pos == POS_MIDDLE || pool_desc[idx].pos == POS_TAIL) begin
      g.status = ST_NOT_START;
    end
    if (g.status == ST_OK) g.start = s;
    return g;
  endfunction

  // Mostly well-formed traffic: small sizes, pointers at live block starts.
  function automatic void draw_request(output cmd_t cmd, output logic [7:0] size,
                                       output logic [7:0] idx, output logic null_ptr);
    int unsigned used;
    int unsigned roll;
    int unsigned first;
    int unsigned c;
    int unsigned k;
    bit          found;
    used = 0;
    for (c = 0; c < POOL_CELLS; c++) used += pool_desc[c].alloc;

    roll = $urandom_range(99);
    if (roll < 80) size = 8'($urandom_range(8, 1));
    else if (roll < 95) size = 8'($urandom_range(POOL_CELLS, 9));
    else if (roll < 97) size = 8'd0;
    else size = 8'($urandom_range(255, POOL_CELLS + 1));

    first = $urandom_range(POOL_CELLS - 1);
    idx = 8'(first);
    found = 1'b0;
    for (c = 0; c < POOL_CELLS && !found; c++) begin
      k = (first + c) % POOL_CELLS;
      if (pool_desc[k].alloc &&
          (pool_desc[k].pos == POS_HEAD || pool_desc[k].pos == POS_LONELY)) begin
        idx = 8'(k);
        found = 1'b1;
      end
    end
    null_ptr = 1'b0;
    roll = $urandom_range(99);
    if (roll < 10) begin
      idx = 8'($urandom_range(POOL_CELLS - 1));
    end else if (roll < 13) begin
      idx = 8'($urandom_range(255, POOL_CELLS));
    end else if (roll < 16) begin
      null_ptr = 1'b1;
      idx = 8'($urandom);
    end

    // Lean toward free once the pool is crowded.
    roll = $urandom_range(99);
    if (used > 44) begin
      cmd = roll < 20 ? CMD_ALLOC : roll < 65 ? CMD_FREE : roll < 80 ? CMD_REALLOC : CMD_CHECK;
    end else begin
      cmd = roll < 45 ? CMD_ALLOC : roll < 65 ? CMD_FREE : roll < 80 ? CMD_REALLOC : CMD_CHECK;
    end

    if ($urandom_range(99) < 6) begin
      cmd = cmd_t'($urandom_range(3));
      size = 8'($urandom);
      idx = 8'($urandom);
      null_ptr = 1'($urandom);
    end
  endfunction

  task automatic offer_request(input cmd_t cmd, input logic [7:0] size,
                               input logic [7:0] idx, input logic null_ptr);
    while ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.command <= cmd;
    req_if.size_cells <= size;
    req_if.cell_index <= idx;
    req_if.pointer_is_null <= null_ptr;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n) begin
      // Check the outgoing grant before queueing a new request's prediction.
      if (rsp_if.valid && rsp_if.ready) begin
        if (pending_grants.size() == 0) begin
          err_count++;
          $display("%0t: unexpected grant status %0d start %0d", $time,
                   rsp_if.status, rsp_if.block_start);
        end else begin
          want = pending_grants.pop_front();
          if (rsp_if.status !== want.status) begin
            err_count++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     rsp_if.status);
          end
          if (rsp_if.block_start !== want.start) begin
            err_count++;
            $display("%0t: block_start expected %0d actual %0d", $time, want.start,
                     rsp_if.block_start);
          end
        end
      end
      if (req_if.valid && req_if.ready) begin
        want = predict_grant(cmd_t'(req_if.command), req_if.size_cells,
                             req_if.cell_index, req_if.pointer_is_null);
        if (row_typed) want = row_grant;
        pending_grants.push_back(want);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(negedge clk) begin
    rsp_if.ready <= !hold_grants && ($urandom_range(99) >= sink_stall_pct);
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (pressure_go);
    hold_grants = 1'b1;
    repeat (PRESSURE_CYCLES) @(posedge clk);
    hold_grants = 1'b0;
  end

  initial begin
    cmd_t       cmd;
    logic [7:0] size;
    logic [7:0] idx;
    logic       null_ptr;
    int         r;
    int         phase;
    int         n;
    req_if.valid = 1'b0;
    req_if.command = CMD_ALLOC;
    req_if.size_cells = 8'd0;
    req_if.cell_index = 8'd0;
    req_if.pointer_is_null = 1'b0;
    rsp_if.ready = 1'b0;
    for (r = 0; r < POOL_CELLS; r++) pool_desc[r] = FREE_CELL;

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < N_DIRECTED; r++) begin
      row_typed = directed_rows[r].typed;
      row_grant = '{status: directed_rows[r].status, start: directed_rows[r].start};
      offer_request(directed_rows[r].cmd, directed_rows[r].size, directed_rows[r].idx,
                    directed_rows[r].null_ptr);
    end
    row_typed = 1'b0;

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 87;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 87;
        end
        3: begin
          src_idle_pct = 29;
          sink_stall_pct = 29;
        end
        default: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
          pressure_go = 1'b1;
        end
      endcase
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        draw_request(cmd, size, idx, null_ptr);
        offer_request(cmd, size, idx, null_ptr);
      end
    end
    req_if.valid <= 1'b0;

    while (pending_grants.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
